### rtl/core/assert_macros.svh
// Assertion macros shared by the wind slot averager RTL.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define WSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define WSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/wsa_pkg.sv
// Package for the wind slot averager: payload and control structs,
// constants and the heading-to-sector function. No dependencies.
package wsa_pkg;

  localparam int SLOT_SECONDS_DEF       = 600;
  localparam int SLOTS_PER_DAY_DEF      = 144;
  localparam int MAX_SLOTS_PER_ITEM_DEF = 64;
  localparam int SECTORS                = 16;

  localparam logic [24:0] SUM_MAX   = 25'h1FFFFFF;
  localparam logic [9:0]  BIN_MAX   = 10'd1023;
  localparam logic [13:0] MEAN_MAX  = 14'd16383;
  localparam logic [4:0]  NO_SECTOR = 5'd16;
  localparam logic [3:0]  SECTOR_N  = 4'd15;

  // Configuration register indexes
  localparam logic [1:0] REG_CALM        = 2'd0;
  localparam logic [1:0] REG_PRIOR_SPEED = 2'd1;
  localparam logic [1:0] REG_PRIOR_DIR   = 2'd2;

  localparam logic [15:0] CALM_RESET = 16'd150;

  typedef struct packed {
    logic [16:0] sample_time;
    logic [15:0] speed;
    logic [11:0] heading;
    logic        end_of_day;
  } wsa_in_t;

  typedef struct packed {
    logic [7:0]  slot_number;
    logic [13:0] mean_speed;
    logic [4:0]  sector;
    logic        gap_error;
    logic        last;
  } wsa_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       mul;
    logic       mul_tail;
    logic       acc;
    logic       prep;
    logic       scan;
    logic [3:0] k;
    logic       report;
    logic       skip;
    logic       gap;
    logic       commit;
  } wsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic day_closed;
    logic gap;
    logic reach;
    logic tail;
    logic out_free;
  } wsa_sts_t;

  // N spans the wrap; other sectors are 22.5 degrees wide from 11.3 degrees.
  function automatic logic [3:0] sector_of(input logic [11:0] h);
    logic [3:0] cnt;
    cnt = '0;
    if (h <= 12'd112 || h >= 12'd3488) begin
      cnt = SECTOR_N;
    end else begin
      for (int j = 1; j < 15; j++) begin
        if (h >= 12'(113 + 225 * j)) cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

endpackage

### rtl/core/wind_slot_average_and_sector.sv
// Wind slot averager with a 16-sector wind rose: every input sample is
// weighted over time into ten-minute slots, and each closed slot yields its
// mean speed in m/s*100 and its dominant direction sector.
//
// Input channel in_valid_i/in_stall_o carries one sample per transfer;
// in_stall_o is high whenever a sample is being worked on. Output channel
// out_valid_o/out_stall_i carries at most one result per sample, held in an
// output register until taken. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_wdata_i): calm threshold, prior speed, prior
// direction.
// A sample that closes no slot passes through check, multiply, add and commit
// before the block is idle again; one that adds no time goes from check
// straight to commit. A closing sample adds up to the slot edge, then runs the
// scan of the 16 sector bins, during which the mean is formed by a reciprocal
// multiply, reports, skips each further slot closed by the same sample and adds
// any tail. A far-ahead sample is dropped and yields a gap result. Reset
// clears all slot state and loads the register defaults; no clearing pass is
// needed. A stalled receiver holds the result register, and the block waits
// before writing a new result until that one is transferred.
module wind_slot_average_and_sector #(
  parameter int SLOT_SECONDS       = wsa_pkg::SLOT_SECONDS_DEF,
  parameter int SLOTS_PER_DAY      = wsa_pkg::SLOTS_PER_DAY_DEF,
  parameter int MAX_SLOTS_PER_ITEM = wsa_pkg::MAX_SLOTS_PER_ITEM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsa_pkg::wsa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsa_pkg::wsa_out_t out_data_o
);
  import wsa_pkg::*;

  `include "assert_macros.svh"

  wsa_cmd_t cmd;
  wsa_sts_t sts;

  wsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsa_dp #(
    .SLOT_SECONDS       (SLOT_SECONDS),
    .SLOTS_PER_DAY      (SLOTS_PER_DAY),
    .MAX_SLOTS_PER_ITEM (MAX_SLOTS_PER_ITEM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Checks
  `WSA_ASSERT(a_sector_range, !out_valid_o || out_data_o.sector <= NO_SECTOR, "sector out of range")
  `WSA_ASSERT(a_gap_fields, !(out_valid_o && out_data_o.gap_error) || (out_data_o.mean_speed == '0 && out_data_o.sector == NO_SECTOR), "gap result fields")
  `WSA_ASSERT_NEXT(a_busy_after_load, in_valid_i && !in_stall_o && !sts.day_closed, in_stall_o, "not busy after transfer")
  `WSA_ASSERT(a_one_write, !(cmd.report && cmd.gap), "two result writes")

endmodule

### rtl/core/wsa_dp.sv
// Datapath of the wind slot averager: held sample, slot sum, sector bins,
// argmax and reciprocal-multiply mean, result register. Uses wsa_pkg.
module wsa_dp #(
  parameter int SLOT_SECONDS       = wsa_pkg::SLOT_SECONDS_DEF,
  parameter int SLOTS_PER_DAY      = wsa_pkg::SLOTS_PER_DAY_DEF,
  parameter int MAX_SLOTS_PER_ITEM = wsa_pkg::MAX_SLOTS_PER_ITEM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  wsa_pkg::wsa_in_t  in_data_i,
  input  wsa_pkg::wsa_cmd_t cmd_i,
  output wsa_pkg::wsa_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsa_pkg::wsa_out_t out_data_o
);
  import wsa_pkg::*;

  localparam int DAY_END  = SLOTS_PER_DAY * SLOT_SECONDS;
  localparam int EDGE_MAX = (SLOTS_PER_DAY + MAX_SLOTS_PER_ITEM + 1) * SLOT_SECONDS;
  localparam int TW       = $clog2(EDGE_MAX + 1);
  localparam int XW       = (TW > 17) ? TW : 17;
  localparam int SW       = $clog2(SLOTS_PER_DAY + 2);
  localparam int DW       = $clog2(SLOT_SECONDS + 1);
  localparam int PW       = 16 + DW;
  localparam int AW       = ((PW > 25) ? PW : 25) + 1;
  localparam int BW       = ((DW > 10) ? DW : 10) + 1;
  localparam int GAP_SPAN = MAX_SLOTS_PER_ITEM * SLOT_SECONDS;
  localparam int DIVISOR  = SLOT_SECONDS * 36;
  // Reciprocal of the divisor, exact for any 29-bit dividend
  localparam int CW       = $clog2(DIVISOR);
  localparam int RS       = 29 + CW;
  localparam longint unsigned RECIP =
    ((64'd1 << RS) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  // Configuration registers
  logic [15:0] calm_q, prior_speed_q;
  logic [11:0] prior_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calm_q        <= CALM_RESET;
      prior_speed_q <= '0;
      prior_dir_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CALM:        calm_q        <= cfg_wdata_i;
        REG_PRIOR_SPEED: prior_speed_q <= cfg_wdata_i;
        REG_PRIOR_DIR:   prior_dir_q   <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // Control state
  logic [TW-1:0] held_time_q, edge_q, cur_q, t_q;
  logic [SW-1:0] slot_q;
  logic          prior_pending_q, eod_q, out_valid_q;

  // Payload state
  logic [15:0]   held_speed_q, spd_in_q;
  logic [11:0]   held_hdg_q, hdg_in_q;
  logic [24:0]   sum_q;
  logic [9:0]    bin_q [SECTORS];
  logic [PW-1:0] prod_q;
  logic [DW-1:0] dur_q;
  logic [3:0]    sec_q, idx_q;
  logic          cnt_q;
  logic [28:0]   rem_q;
  logic [28:0]   quo_q;
  logic [9:0]    best_q;
  logic [PW-1:0] calm_s_q;
  wsa_out_t      out_q;

  // Input time clamped to the day and to the held time
  logic [XW-1:0] t_ext, t_day;
  logic [TW-1:0] t_clamp;
  always_comb begin
    t_ext = XW'(in_data_i.sample_time);
    t_day = (in_data_i.end_of_day || t_ext > XW'(DAY_END)) ? XW'(DAY_END) : t_ext;
    t_clamp = (TW'(t_day) < held_time_q) ? held_time_q : TW'(t_day);
  end

  // Interval product operands
  logic [15:0]   spd_sel;
  logic [11:0]   hdg_sel;
  logic [DW-1:0] dur;
  always_comb begin
    spd_sel = prior_pending_q ? prior_speed_q : held_speed_q;
    hdg_sel = prior_pending_q ? prior_dir_q : held_hdg_q;
    dur     = cmd_i.mul_tail ? DW'(t_q - cur_q) : DW'(edge_q - cur_q);
  end

  // Saturating accumulators
  logic [AW-1:0] sum_add;
  logic [BW-1:0] bin_add;
  logic [3:0]    rd_idx;
  logic [9:0]    bin_rd;
  always_comb begin
    rd_idx  = cmd_i.scan ? cmd_i.k : sec_q;
    bin_rd  = bin_q[rd_idx];
    sum_add = AW'(sum_q) + AW'(prod_q);
    bin_add = BW'(bin_rd) + BW'(dur_q);
  end

  // Result fields of a closing slot
  logic [AW-1:0] sum_cmp, calm_cmp;
  logic [59:0]   mean_prod;
  logic [28:0]   mean_quo;
  logic [4:0]    close_sector;
  logic [13:0]   close_mean;
  always_comb begin
    sum_cmp      = AW'(sum_q);
    calm_cmp     = AW'(calm_s_q);
    mean_prod    = 60'(rem_q) * 60'(RECIP);
    mean_quo     = 29'(mean_prod >> RS);
    close_sector = (sum_cmp > calm_cmp && best_q != '0) ? {1'b0, idx_q} : NO_SECTOR;
    close_mean   = (quo_q > 29'(MEAN_MAX)) ? MEAN_MAX : quo_q[13:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_time_q     <= '0;
      edge_q          <= TW'(SLOT_SECONDS);
      cur_q           <= '0;
      t_q             <= '0;
      slot_q          <= '0;
      prior_pending_q <= 1'b1;
      eod_q           <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        t_q   <= t_clamp;
        eod_q <= in_data_i.end_of_day;
        cur_q <= held_time_q;
      end
      if (cmd_i.report || cmd_i.skip) begin
        slot_q <= slot_q + SW'(1);
        cur_q  <= edge_q;
        edge_q <= edge_q + TW'(SLOT_SECONDS);
      end
      if (cmd_i.commit) begin
        held_time_q <= t_q;
        if (!eod_q) prior_pending_q <= 1'b0;
      end
      if (cmd_i.report || cmd_i.gap) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Slot sum and sector bins, cleared at reset and on each reported close
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < SECTORS; i++) bin_q[i] <= '0;
    end else if (cmd_i.report) begin
      sum_q <= '0;
      for (int i = 0; i < SECTORS; i++) bin_q[i] <= '0;
    end else if (cmd_i.acc) begin
      sum_q <= (sum_add > AW'(SUM_MAX)) ? SUM_MAX : sum_add[24:0];
      if (cnt_q) bin_q[sec_q] <= (bin_add > BW'(BIN_MAX)) ? BIN_MAX : bin_add[9:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      spd_in_q <= in_data_i.speed;
      hdg_in_q <= in_data_i.heading;
    end
    if (cmd_i.commit && !eod_q) begin
      held_speed_q <= spd_in_q;
      held_hdg_q   <= hdg_in_q;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(spd_sel) * PW'(dur);
      dur_q  <= dur;
      sec_q  <= sector_of(hdg_sel);
      cnt_q  <= prior_pending_q || (spd_sel > calm_q);
    end
    // Argmax setup and scaled sum for the mean
    if (cmd_i.prep) begin
      rem_q    <= (29'(sum_q) << 3) + (29'(sum_q) << 1);
      best_q   <= '0;
      idx_q    <= '0;
      calm_s_q <= PW'(calm_q) * PW'(SLOT_SECONDS);
    end
    // One bin per cycle; the mean quotient settles during the scan
    if (cmd_i.scan) begin
      if (bin_rd >= best_q) begin
        best_q <= bin_rd;
        idx_q  <= cmd_i.k;
      end
      quo_q <= mean_quo;
    end
    if (cmd_i.report) begin
      out_q.slot_number <= 8'(slot_q);
      out_q.mean_speed  <= close_mean;
      out_q.sector      <= close_sector;
      out_q.gap_error   <= 1'b0;
      out_q.last        <= 1'b1;
    end else if (cmd_i.gap) begin
      out_q.slot_number <= 8'(slot_q);
      out_q.mean_speed  <= '0;
      out_q.sector      <= NO_SECTOR;
      out_q.gap_error   <= 1'b1;
      out_q.last        <= 1'b1;
    end
  end

  // Status
  always_comb begin
    sts_o.day_closed = slot_q >= SW'(SLOTS_PER_DAY);
    sts_o.gap        = !eod_q && (t_q >= edge_q + TW'(GAP_SPAN));
    sts_o.reach      = t_q >= edge_q;
    sts_o.tail       = (slot_q < SW'(SLOTS_PER_DAY)) && (t_q > cur_q);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/wsa_ctrl.sv
// Controller of the wind slot averager: sequences one sample through
// interval add, slot close, skipped slots and commit, or a gap result. Uses wsa_pkg.
module wsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsa_pkg::wsa_sts_t sts_i,
  output wsa_pkg::wsa_cmd_t cmd_o
);
  import wsa_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_MUL_EDGE = 4'd2;
  localparam logic [3:0] S_ACC_EDGE = 4'd3;
  localparam logic [3:0] S_PREP     = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_REPORT   = 4'd6;
  localparam logic [3:0] S_SKIP     = 4'd7;
  localparam logic [3:0] S_MUL_TAIL = 4'd8;
  localparam logic [3:0] S_ACC_TAIL = 4'd9;
  localparam logic [3:0] S_COMMIT   = 4'd10;
  localparam logic [3:0] S_GAP      = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] k_q, k_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.k = k_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !sts_i.day_closed) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts_i.gap) state_d = S_GAP;
        else if (sts_i.reach)   state_d = S_MUL_EDGE;
        else if (sts_i.tail)    state_d = S_MUL_TAIL;
        else                    state_d = S_COMMIT;
      end
      S_MUL_EDGE: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC_EDGE;
      end
      S_ACC_EDGE: begin
        cmd_o.acc = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        k_d        = '0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        k_d        = k_q + 4'd1;
        if (k_q == 4'(SECTORS - 1)) state_d = S_REPORT;
      end
      S_REPORT: begin
        if (sts_i.out_free) begin
          cmd_o.report = 1'b1;
          state_d      = S_SKIP;
        end
      end
      // Slots wholly covered by the held sample close without a result
      S_SKIP: begin
        priority if (sts_i.reach) cmd_o.skip = 1'b1;
        else if (sts_i.tail)      state_d = S_MUL_TAIL;
        else                      state_d = S_COMMIT;
      end
      S_MUL_TAIL: begin
        cmd_o.mul      = 1'b1;
        cmd_o.mul_tail = 1'b1;
        state_d        = S_ACC_TAIL;
      end
      S_ACC_TAIL: begin
        cmd_o.acc = 1'b1;
        state_d   = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_IDLE;
      end
      S_GAP: begin
        if (sts_i.out_free) begin
          cmd_o.gap = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

endmodule
